@@ rtl/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared widths, codes, reset values and channel types of the chamber
// cycle sequencer.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int ADC_BITS      = 12;
    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = ADC_BITS + COUNT_BITS;
    localparam int TS_BITS       = 32;
    localparam int MS_BITS       = 24;
    localparam int PHASE_BITS    = 2;
    localparam int STEP_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

    // chamber phases
    localparam logic [PHASE_BITS-1:0] PH_FILL     = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_AERATION = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_MEASURE  = 2'd2;
    localparam logic [PHASE_BITS-1:0] PH_DRAIN    = 2'd3;

    // averaging steps
    localparam logic [STEP_BITS-1:0] STEP_AVAILABLE = 2'd0;
    localparam logic [STEP_BITS-1:0] STEP_DETECT    = 2'd1;
    localparam logic [STEP_BITS-1:0] STEP_CALIBRATE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRAIN_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AERATION_MS     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEASURE_MS      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_THRESHOLD = 3'd4;

    // configuration reset values
    localparam logic [ADC_BITS-1:0] FILL_LEVEL_RST      = ADC_BITS'(1638);
    localparam logic [ADC_BITS-1:0] DRAIN_LEVEL_RST     = ADC_BITS'(819);
    localparam logic [MS_BITS-1:0]  AERATION_MS_RST     = MS_BITS'(5000);
    localparam logic [MS_BITS-1:0]  MEASURE_MS_RST      = MS_BITS'(5000);
    localparam logic [ADC_BITS-1:0] ALARM_THRESHOLD_RST = ADC_BITS'(410);

    typedef struct packed {
        logic [TS_BITS-1:0]  now_ms;
        logic [ADC_BITS-1:0] upper_level;
        logic [ADC_BITS-1:0] lower_level;
        logic [ADC_BITS-1:0] ammonia_sample;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic                  air_valve_closed;
        logic                  aeration_pump_on;
        logic                  water_pump_on;
        logic                  water_valve_closed;
        logic [ADC_BITS-1:0]   ammonia_average;
        logic                  alarm;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] value;
    } t_cfg_write;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic div_step;
        logic div_last;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

@@ rtl/ccs_stream_if.sv @@
// ----------------------------------------------------------------------------
// ccs_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ccs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ccs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ccs_ctrl
// Pass sequencer: takes a beat, runs the divider when needed, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module ccs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ccs_pkg::t_dp_stat  i_stat,
    output ccs_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    localparam logic [ccs_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
        ccs_pkg::DIV_CNT_BITS'(ccs_pkg::SUM_BITS - 1);

    logic [1:0]                        r_state, n_state;
    logic [ccs_pkg::DIV_CNT_BITS-1:0]  r_div_cnt, n_div_cnt;
    logic                              r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = i_stat.need_div ? S_DIV : S_RES;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_RES;
                end
            end
            S_RES: begin
                // wait for the output slot to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/ccs_datapath.sv @@
// ----------------------------------------------------------------------------
// ccs_datapath
// Phase registers, sample accumulator, restoring divider, configuration
// registers and the output register.
// ----------------------------------------------------------------------------
module ccs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccs_pkg::t_dp_cmd    i_cmd,
    output ccs_pkg::t_dp_stat   o_stat,
    input  ccs_pkg::t_in_item   i_item,
    input  logic                i_cfg_we,
    input  ccs_pkg::t_cfg_write i_cfg,
    output ccs_pkg::t_out_item  o_item
);

    localparam logic [ccs_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    // configuration
    logic [ccs_pkg::ADC_BITS-1:0] r_fill_level, r_drain_level, r_alarm_thr;
    logic [ccs_pkg::MS_BITS-1:0]  r_aeration_ms, r_measure_ms;

    // sequencing state
    logic [ccs_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [ccs_pkg::TS_BITS-1:0]    r_start, n_start;
    logic [ccs_pkg::SUM_BITS-1:0]   r_sum, n_sum;
    logic [ccs_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [ccs_pkg::STEP_BITS-1:0]  r_step, n_step;
    logic [ccs_pkg::ADC_BITS-1:0]   r_pending, n_pending;
    logic [ccs_pkg::ADC_BITS-1:0]   r_published, n_published;

    // divider and result
    logic [ccs_pkg::COUNT_BITS-1:0] r_rem, n_rem;
    logic [ccs_pkg::SUM_BITS-1:0]   r_quo, n_quo;
    logic [ccs_pkg::COUNT_BITS:0]   trial;
    ccs_pkg::t_out_item             r_res, n_res;
    ccs_pkg::t_out_item             r_out, n_out;

    logic [ccs_pkg::TS_BITS-1:0]    elapsed;
    logic [ccs_pkg::STEP_BITS-1:0]  step_eff;

    assign elapsed = i_item.now_ms - r_start;
    assign trial   = {r_rem, r_quo[ccs_pkg::SUM_BITS-1]};

    assign o_stat.need_div = (r_phase == ccs_pkg::PH_DRAIN) && (r_count != '0);

    always_comb begin
        n_phase     = r_phase;
        n_start     = r_start;
        n_sum       = r_sum;
        n_count     = r_count;
        n_step      = r_step;
        n_pending   = r_pending;
        n_published = r_published;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_res       = r_res;
        n_out       = r_out;
        step_eff    = r_step;

        if (i_cmd.exec) begin
            n_res                    = '0;
            n_res.phase              = r_phase;
            n_res.air_valve_closed   = 1'b1;
            n_res.water_valve_closed = 1'b1;

            case (r_phase)
                ccs_pkg::PH_FILL: begin
                    n_res.water_pump_on = 1'b1;
                    if (i_item.upper_level >= r_fill_level) begin
                        n_phase = ccs_pkg::PH_AERATION;
                        n_start = i_item.now_ms;
                    end
                end
                ccs_pkg::PH_AERATION: begin
                    n_res.aeration_pump_on = 1'b1;
                    if (elapsed > ccs_pkg::TS_BITS'(r_aeration_ms)) begin
                        n_phase = ccs_pkg::PH_MEASURE;
                        n_start = i_item.now_ms;
                    end
                end
                ccs_pkg::PH_MEASURE: begin
                    if (elapsed > ccs_pkg::TS_BITS'(r_measure_ms)) begin
                        n_phase = ccs_pkg::PH_DRAIN;
                    end
                    step_eff = ccs_pkg::STEP_DETECT;
                end
                default: begin
                    n_res.air_valve_closed   = 1'b0;
                    n_res.water_valve_closed = 1'b0;
                    if (i_item.lower_level <= r_drain_level) begin
                        n_phase = ccs_pkg::PH_FILL;
                    end
                    step_eff = ccs_pkg::STEP_CALIBRATE;
                end
            endcase

            case (step_eff)
                ccs_pkg::STEP_DETECT: begin
                    n_step = ccs_pkg::STEP_DETECT;
                    if (r_count != COUNT_MAX) begin
                        n_sum   = r_sum + ccs_pkg::SUM_BITS'(i_item.ammonia_sample);
                        n_count = r_count + 1'b1;
                    end
                end
                ccs_pkg::STEP_CALIBRATE: begin
                    // quotient comes from the divider unless nothing was summed
                    n_step = ccs_pkg::STEP_AVAILABLE;
                    if (r_count == '0) begin
                        n_pending = '0;
                    end
                end
                default: begin
                    n_step      = ccs_pkg::STEP_AVAILABLE;
                    n_published = r_pending;
                    n_sum       = '0;
                    n_count     = '0;
                end
            endcase

            n_quo = r_sum;
            n_rem = '0;
        end

        if (i_cmd.div_step) begin
            if (trial >= {1'b0, r_count}) begin
                n_rem = ccs_pkg::COUNT_BITS'(trial - {1'b0, r_count});
                n_quo = {r_quo[ccs_pkg::SUM_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial[ccs_pkg::COUNT_BITS-1:0];
                n_quo = {r_quo[ccs_pkg::SUM_BITS-2:0], 1'b0};
            end
            if (i_cmd.div_last) begin
                n_pending = n_quo[ccs_pkg::ADC_BITS-1:0];
            end
        end

        if (i_cmd.load_out) begin
            n_out                 = r_res;
            n_out.ammonia_average = r_published;
            n_out.alarm           = (r_published >= r_alarm_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ccs_pkg::PH_FILL;
            r_start     <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_step      <= ccs_pkg::STEP_AVAILABLE;
            r_pending   <= '0;
            r_published <= '0;
        end else begin
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_step      <= n_step;
            r_pending   <= n_pending;
            r_published <= n_published;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_res <= n_res;
        r_out <= n_out;
    end

    // register file, writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_level  <= ccs_pkg::FILL_LEVEL_RST;
            r_drain_level <= ccs_pkg::DRAIN_LEVEL_RST;
            r_aeration_ms <= ccs_pkg::AERATION_MS_RST;
            r_measure_ms  <= ccs_pkg::MEASURE_MS_RST;
            r_alarm_thr   <= ccs_pkg::ALARM_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                ccs_pkg::CFG_FILL_LEVEL:
                    r_fill_level <= i_cfg.value[ccs_pkg::ADC_BITS-1:0];
                ccs_pkg::CFG_DRAIN_LEVEL:
                    r_drain_level <= i_cfg.value[ccs_pkg::ADC_BITS-1:0];
                ccs_pkg::CFG_AERATION_MS:
                    r_aeration_ms <= i_cfg.value[ccs_pkg::MS_BITS-1:0];
                ccs_pkg::CFG_MEASURE_MS:
                    r_measure_ms <= i_cfg.value[ccs_pkg::MS_BITS-1:0];
                ccs_pkg::CFG_ALARM_THRESHOLD:
                    r_alarm_thr <= i_cfg.value[ccs_pkg::ADC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_item = r_out;

endmodule

@@ rtl/chamber_cycle_sequencer.sv @@
// ----------------------------------------------------------------------------
// chamber_cycle_sequencer
// Fill / aeration / measure / drain sequencer for a water sampling chamber
// with ammonia averaging and alarm.
// ----------------------------------------------------------------------------
// Each input beat is one control pass (millisecond timestamp plus upper level,
// lower level and ammonia ADC codes) and yields exactly one output beat with
// the phase that began the pass, the valve and pump drives for that phase, the
// published ammonia average and the alarm. One pass is handled at a time: a
// pass runs the accept state, then the output register load state, and its
// result is valid once loaded into the output register; a drain pass with
// samples collected also runs the 28-step restoring divider (one quotient
// bit per cycle) in between. A result still waiting in the output register
// holds off the load, and with it the next accept, until that beat is taken.
// The output register is separate, so a result may wait there while the next
// pass is accepted. The configuration channel is always ready and takes
// writes at any time; writes are meant to happen while no pass is in flight.
// ----------------------------------------------------------------------------
module chamber_cycle_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ccs_stream_if.sink   i_in,
    ccs_stream_if.source o_out,
    ccs_stream_if.sink   i_cfg
);

    ccs_pkg::t_dp_cmd  cmd;
    ccs_pkg::t_dp_stat stat;
    logic              cfg_we;

    // config is a plain register write, never back-pressured
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    // sequencer: accept, optional divide, output load
    ccs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // phase logic, accumulator, divider, config and output register
    ccs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_item   (i_in.data),
        .i_cfg_we (cfg_we),
        .i_cfg    (i_cfg.data),
        .o_item   (o_out.data)
    );

endmodule

@@ verif/tb_chamber_cycle_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chamber_cycle_sequencer
// Self-checking bench for the chamber cycle sequencer: walks the chamber
// through fill, aeration, measure and drain under several register settings,
// predicts drives, published average and alarm for every pass, and compares
// each output beat against that prediction.
// ----------------------------------------------------------------------------
module tb_chamber_cycle_sequencer;

    import ccs_pkg::*;

    localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
    localparam int MAX_GAP      = 13;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2_000_000;
    // measure passes in the long stretch with the widest measure time
    localparam int LONG_PASSES  = 40;
    localparam int RAND_PHASES  = 10;
    localparam int PASSES_EACH  = 70;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of registers and chamber state, one expected
    // output beat per accepted pass
    // ------------------------------------------------------------------------
    class chamber_scoreboard;
        localparam int REPORT_LIMIT = 10;

        logic [ADC_BITS-1:0]   fill_level;
        logic [ADC_BITS-1:0]   drain_level;
        logic [MS_BITS-1:0]    aeration_ms;
        logic [MS_BITS-1:0]    measure_ms;
        logic [ADC_BITS-1:0]   alarm_threshold;

        logic [PHASE_BITS-1:0] phase;
        logic [TS_BITS-1:0]    phase_start;
        logic [SUM_BITS-1:0]   sample_sum;
        logic [COUNT_BITS-1:0] sample_count;
        logic [STEP_BITS-1:0]  step;
        logic [ADC_BITS-1:0]   pending_avg;
        logic [ADC_BITS-1:0]   published_avg;

        t_out_item expected_drives[$];
        int        errors;

        function new();
            fill_level      = FILL_LEVEL_RST;
            drain_level     = DRAIN_LEVEL_RST;
            aeration_ms     = AERATION_MS_RST;
            measure_ms      = MEASURE_MS_RST;
            alarm_threshold = ALARM_THRESHOLD_RST;
            phase           = PH_FILL;
            phase_start     = '0;
            sample_sum      = '0;
            sample_count    = '0;
            step            = STEP_AVAILABLE;
            pending_avg     = '0;
            published_avg   = '0;
            errors          = 0;
        endfunction

        // narrow registers keep only their low bits, unknown indexes are dropped
        function void write_reg(t_cfg_write w);
            case (w.index)
                CFG_FILL_LEVEL:      fill_level      = w.value[ADC_BITS-1:0];
                CFG_DRAIN_LEVEL:     drain_level     = w.value[ADC_BITS-1:0];
                CFG_AERATION_MS:     aeration_ms     = w.value[MS_BITS-1:0];
                CFG_MEASURE_MS:      measure_ms      = w.value[MS_BITS-1:0];
                CFG_ALARM_THRESHOLD: alarm_threshold = w.value[ADC_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void predict_drives(t_in_item p);
            logic [TS_BITS-1:0] elapsed;
            t_out_item          r;
            // elapsed time wraps with the timestamp
            elapsed              = p.now_ms - phase_start;
            r                    = '0;
            r.phase              = phase;
            r.air_valve_closed   = 1'b1;
            r.water_valve_closed = 1'b1;
            case (phase)
                PH_FILL: begin
                    r.water_pump_on = 1'b1;
                    if (p.upper_level >= fill_level) begin
                        phase       = PH_AERATION;
                        phase_start = p.now_ms;
                    end
                end
                PH_AERATION: begin
                    r.aeration_pump_on = 1'b1;
                    if (elapsed > TS_BITS'(aeration_ms)) begin
                        phase       = PH_MEASURE;
                        phase_start = p.now_ms;
                    end
                end
                PH_MEASURE: begin
                    // start time is kept when leaving for drain
                    if (elapsed > TS_BITS'(measure_ms))
                        phase = PH_DRAIN;
                    step = STEP_DETECT;
                end
                default: begin
                    r.air_valve_closed   = 1'b0;
                    r.water_valve_closed = 1'b0;
                    if (p.lower_level <= drain_level)
                        phase = PH_FILL;
                    step = STEP_CALIBRATE;
                end
            endcase
            case (step)
                STEP_DETECT: begin
                    // saturated count freezes sum and count
                    if (sample_count != '1) begin
                        sample_sum   = sample_sum + SUM_BITS'(p.ammonia_sample);
                        sample_count = sample_count + 1'b1;
                    end
                end
                STEP_CALIBRATE: begin
                    pending_avg = (sample_count != '0) ?
                                  ADC_BITS'(sample_sum / SUM_BITS'(sample_count)) : '0;
                    step        = STEP_AVAILABLE;
                end
                default: begin
                    step          = STEP_AVAILABLE;
                    published_avg = pending_avg;
                    sample_sum    = '0;
                    sample_count  = '0;
                end
            endcase
            r.ammonia_average = published_avg;
            r.alarm           = (published_avg >= alarm_threshold);
            expected_drives.push_back(r);
        endfunction

        function void check_drives(t_out_item got);
            t_out_item want;
            if (expected_drives.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("[%0t] output beat with nothing expected: %h", $realtime, got);
                return;
            end
            want = expected_drives.pop_front();
            if (got.phase !== want.phase ||
                got.air_valve_closed !== want.air_valve_closed ||
                got.aeration_pump_on !== want.aeration_pump_on ||
                got.water_pump_on !== want.water_pump_on ||
                got.water_valve_closed !== want.water_valve_closed ||
                got.ammonia_average !== want.ammonia_average ||
                got.alarm !== want.alarm) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("[%0t] exp: ph %0d air %b aer %b pump %b wtr %b avg %0d alm %b",
                             $realtime, want.phase, want.air_valve_closed,
                             want.aeration_pump_on, want.water_pump_on,
                             want.water_valve_closed, want.ammonia_average, want.alarm);
                    $display("[%0t] got: ph %0d air %b aer %b pump %b wtr %b avg %0d alm %b",
                             $realtime, got.phase, got.air_valve_closed,
                             got.aeration_pump_on, got.water_pump_on,
                             got.water_valve_closed, got.ammonia_average, got.alarm);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ccs_stream_if #(.t_payload(t_in_item))   in_if  ();
    ccs_stream_if #(.t_payload(t_out_item))  out_if ();
    ccs_stream_if #(.t_payload(t_cfg_write)) cfg_if ();

    chamber_cycle_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    chamber_scoreboard sb = new();

    bit                 idle_on     = 1'b1;   // random gaps on both sides
    bit                 hold_output = 1'b0;   // receiver long hold-off request
    logic [TS_BITS-1:0] last_ms     = '0;     // timestamp of the last generated pass
    int                 cycle_count = 0;

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_cfg_write cfg_beat(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] val);
        t_cfg_write w;
        w.index = idx;
        w.value = val;
        return w;
    endfunction

    // next control pass, shaped by where the chamber is predicted to be;
    // advance forces the beat that leaves the current phase
    function automatic t_in_item gen_pass(input bit advance);
        t_in_item           p;
        logic [TS_BITS-1:0] limit;
        int                 roll;
        int                 exit_pct;
        roll          = $urandom_range(0, 99);
        p.now_ms      = last_ms + TS_BITS'($urandom_range(0, 200));
        p.upper_level = ADC_BITS'($urandom);
        p.lower_level = ADC_BITS'($urandom);
        case ($urandom_range(0, 3))
            0:       p.ammonia_sample = '0;
            1:       p.ammonia_sample = ADC_BITS'(ADC_MAX);
            default: p.ammonia_sample = ADC_BITS'($urandom);
        endcase
        if (!advance && roll < 15) begin
            // noise beat: any timestamp, any levels
            p.now_ms = $urandom;
        end else begin
            case (sb.phase)
                PH_FILL: begin
                    if (advance || roll < 55)
                        p.upper_level = ADC_BITS'($urandom_range(sb.fill_level, ADC_MAX));
                    else if (sb.fill_level != 0)
                        p.upper_level = ADC_BITS'($urandom_range(0, sb.fill_level - 1));
                end
                PH_AERATION, PH_MEASURE: begin
                    limit    = (sb.phase == PH_AERATION) ? TS_BITS'(sb.aeration_ms) :
                                                           TS_BITS'(sb.measure_ms);
                    // measure lingers longer so several samples pile up
                    exit_pct = (sb.phase == PH_AERATION) ? 60 : 35;
                    if (advance || roll < 15 + exit_pct)
                        p.now_ms = sb.phase_start + limit + 1 + $urandom_range(0, 3);
                    else if (roll < 90)
                        p.now_ms = sb.phase_start + limit;   // exactly at the limit, stays
                    else
                        p.now_ms = sb.phase_start + $urandom_range(0, limit);
                end
                default: begin
                    if (advance || roll < 55)
                        p.lower_level = ADC_BITS'($urandom_range(0, sb.drain_level));
                    else if (sb.drain_level != ADC_MAX)
                        p.lower_level = ADC_BITS'($urandom_range(sb.drain_level + 1, ADC_MAX));
                end
            endcase
        end
        last_ms = p.now_ms;
        return p;
    endfunction

    // one input beat; valid stays high when the next beat follows without a gap
    task automatic send_pass(input t_in_item p);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= p;
        do @(posedge i_clk); while (!in_if.ready);
        sb.predict_drives(p);
    endtask

    task automatic send_fields(input logic [TS_BITS-1:0] now_ms,
                               input logic [ADC_BITS-1:0] upper,
                               input logic [ADC_BITS-1:0] lower,
                               input logic [ADC_BITS-1:0] ammonia);
        t_in_item p;
        p.now_ms         = now_ms;
        p.upper_level    = upper;
        p.lower_level    = lower;
        p.ammonia_sample = ammonia;
        last_ms          = now_ms;
        send_pass(p);
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.expected_drives.size() != 0) @(posedge i_clk);
    endtask

    // back-to-back register writes, valid held across the burst
    task automatic program_regs(input t_cfg_write writes[$]);
        foreach (writes[k]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= writes[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            sb.write_reg(writes[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_output) begin
                // long hold-off so the block backs up into its input
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
                if (stall != 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    // every accepted output beat is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_drives(out_if.data);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_cfg_write                writes[$];
        t_cfg_write                w;
        logic [CFG_DATA_BITS-1:0]  val;
        logic [TS_BITS-1:0]        t_aer;
        logic [TS_BITS-1:0]        t_meas;
        int                        roll;

        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset settings, alarm low with the reset threshold
        send_fields('0, '0, ADC_BITS'(ADC_MAX), ADC_BITS'(ADC_MAX));
        send_fields('1, FILL_LEVEL_RST - 1'b1, '0, '0);

        // zero threshold: alarm high while the average is still zero
        settle();
        writes.delete();
        writes.push_back(cfg_beat(CFG_ALARM_THRESHOLD, '0));
        program_regs(writes);

        // fill level reached just below the timestamp wrap
        t_aer = 32'hFFFF_FF00;
        send_fields(t_aer, FILL_LEVEL_RST, ADC_BITS'(ADC_MAX), '0);
        // aeration time met exactly across the wrap, then exceeded by one
        send_fields(t_aer + AERATION_MS_RST, ADC_BITS'(ADC_MAX), '0, ADC_BITS'(ADC_MAX));
        t_meas = t_aer + AERATION_MS_RST + 1;
        send_fields(t_meas, '0, '0, '0);
        // measure: extreme samples, limit met then exceeded
        send_fields(t_meas, '0, '0, ADC_BITS'(ADC_MAX));
        send_fields(t_meas + 1, ADC_BITS'(ADC_MAX), '0, '0);
        send_fields(t_meas + MEASURE_MS_RST, '0, '0, ADC_BITS'(ADC_MAX));
        send_fields(t_meas + MEASURE_MS_RST + 1, '0, '0, 12'd1);
        // drain: one code above the drain level stays, at the level leaves
        send_fields(t_meas + 32'd20000, '0, DRAIN_LEVEL_RST + 1'b1, ADC_BITS'(ADC_MAX));
        send_fields(t_meas + 32'd20001, '0, DRAIN_LEVEL_RST, '0);
        // first fill pass publishes the floor average
        send_fields(t_meas + 32'd20002, '0, ADC_BITS'(ADC_MAX), '0);

        // threshold equal to the published average, then one above
        settle();
        writes.delete();
        writes.push_back(cfg_beat(CFG_ALARM_THRESHOLD, 24'd2047));
        program_regs(writes);
        send_fields(t_meas + 32'd20003, '0, '0, '0);
        settle();
        writes.delete();
        writes.push_back(cfg_beat(CFG_ALARM_THRESHOLD, 24'd2048));
        program_regs(writes);
        send_fields(t_meas + 32'd20004, '0, '0, '0);

        // --- random phases: all registers rewritten each time, extremes first
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            writes.delete();
            for (int r = CFG_FILL_LEVEL; r <= CFG_ALARM_THRESHOLD; r++) begin
                w.index = CFG_IDX_BITS'(r);
                roll    = $urandom_range(0, 4);
                if (ph == 0 || (ph > 1 && roll == 0))
                    val = '0;
                else if (ph == 1 || roll == 1)
                    val = '1;
                else if (w.index == CFG_AERATION_MS || w.index == CFG_MEASURE_MS)
                    val = CFG_DATA_BITS'($urandom_range(0, 20000));
                else
                    val = CFG_DATA_BITS'($urandom);
                // junk above the narrow registers, must be dropped
                if (w.index != CFG_AERATION_MS && w.index != CFG_MEASURE_MS)
                    val[CFG_DATA_BITS-1:ADC_BITS] = (CFG_DATA_BITS-ADC_BITS)'($urandom);
                w.value = val;
                writes.push_back(w);
            end
            // unmapped index, ignored
            if ($urandom_range(0, 2) == 0)
                writes.push_back(cfg_beat(CFG_IDX_BITS'($urandom_range(CFG_ALARM_THRESHOLD + 1,
                                          (1 << CFG_IDX_BITS) - 1)), CFG_DATA_BITS'($urandom)));
            program_regs(writes);

            idle_on = (ph % 3 != 2);
            if (ph == 4) begin
                // sender keeps pushing while the receiver holds off
                idle_on     = 1'b0;
                hold_output = 1'b1;
            end
            for (int i = 0; i < PASSES_EACH; i++)
                send_pass(gen_pass(1'b0));
        end

        // --- long measure stretch with the widest measure time
        settle();
        writes.delete();
        writes.push_back(cfg_beat(CFG_FILL_LEVEL, '0));
        writes.push_back(cfg_beat(CFG_DRAIN_LEVEL, CFG_DATA_BITS'(ADC_MAX)));
        writes.push_back(cfg_beat(CFG_AERATION_MS, '0));
        writes.push_back(cfg_beat(CFG_MEASURE_MS, '1));
        writes.push_back(cfg_beat(CFG_ALARM_THRESHOLD, CFG_DATA_BITS'($urandom_range(0, ADC_MAX))));
        program_regs(writes);
        idle_on = 1'b0;
        while (sb.phase != PH_MEASURE)
            send_pass(gen_pass(1'b1));
        for (int i = 0; i < LONG_PASSES; i++)
            send_fields(sb.phase_start, ADC_BITS'($urandom), ADC_BITS'($urandom),
                        ADC_BITS'($urandom));
        while (sb.phase != PH_FILL)
            send_pass(gen_pass(1'b1));
        // publish the long-run average
        send_pass(gen_pass(1'b1));

        // --- wind down: everything back, then let any stray beat show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_drives.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ chamber_cycle_sequencer.f @@
rtl/ccs_pkg.sv
rtl/ccs_stream_if.sv
rtl/ccs_ctrl.sv
rtl/ccs_datapath.sv
rtl/chamber_cycle_sequencer.sv
verif/tb_chamber_cycle_sequencer.sv
